>>> sv/sle_pkg.sv
`default_nettype none

package sle_pkg;

  localparam int OP_W          = 3;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 4;
  localparam int STATUS_W      = 2;
  localparam int FOUND_W       = 4;
  localparam int ENTRY_COUNT_W = 5;
  localparam int CAPACITY_DEF  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_ALTER  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADPOS   = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
    logic rewind;
    logic capture;
    logic append;
    logic alter;
    logic clear;
    logic dec;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic pos_ok;
    logic match;
    logic scan_end;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/sequential_list_engine.sv
// Append, alter, clear and unused codes finish in the decode state. Search and remove scan
// the entries from index 0 until a match or the end of the list; a remove that hits then
// shifts the later entries down one place. One transaction at a time, and a new one is
// accepted in the strobe cycle. Results cannot stall.
// Synchronous active-low reset empties the list; memory is not cleared.
`default_nettype none

module sequential_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sle_pkg::OP_W-1:0]             in_operation,
  input  logic signed [sle_pkg::VALUE_W-1:0]   in_value,
  input  logic [sle_pkg::POS_W-1:0]            in_position,
  output logic                                 out_valid,
  output logic [sle_pkg::STATUS_W-1:0]         out_status,
  output logic [sle_pkg::FOUND_W-1:0]          out_found_index,
  output logic [sle_pkg::ENTRY_COUNT_W-1:0]    out_entry_count
);
  import sle_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  sle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_position  (in_position),
    .found_index  (out_found_index),
    .entry_count  (out_entry_count)
  );

`ifndef SYNTHESIS
  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe raised while a transaction is still in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not make the engine busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_entry_count == ENTRY_COUNT_W'(CAPACITY))
    else $error("list full reported with an entry count below capacity");

  a_index_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_found_index != '0) |-> out_status == ST_DONE)
    else $error("non-zero found index reported with a failing status");
`endif

endmodule

`default_nettype wire

>>> sv/sle_dp.sv
`default_nettype none

module sle_dp #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sle_pkg::dp_cmd_t                     cmd,
  output sle_pkg::dp_sts_t                     sts,
  input  logic [sle_pkg::OP_W-1:0]             in_operation,
  input  logic signed [sle_pkg::VALUE_W-1:0]   in_value,
  input  logic [sle_pkg::POS_W-1:0]            in_position,
  output logic [sle_pkg::FOUND_W-1:0]          found_index,
  output logic [sle_pkg::ENTRY_COUNT_W-1:0]    entry_count
);
  import sle_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PTR_W = $clog2(CAPACITY + 2);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  op_t                       op_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]          pos_r;
  logic [CNT_W-1:0]          count_r;
  logic [PTR_W-1:0]          ptr_r;
  logic [IDX_W-1:0]          chk_idx_r;
  logic                      pend_r;
  logic                      inr_r;
  logic signed [VALUE_W-1:0] rdata_r;
  logic [IDX_W-1:0]          hit_r;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic signed [VALUE_W-1:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = value_r;
    priority if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.alter) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(pos_r);
    end else if (cmd.shift && pend_r && inr_r) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx_r - IDX_W'(1);
      wr_data = rdata_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.step) begin
      rdata_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      value_r <= in_value;
      pos_r   <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ptr_r     <= '0;
      pend_r    <= 1'b0;
      inr_r     <= 1'b0;
      chk_idx_r <= '0;
      hit_r     <= '0;
    end else begin
      if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.dec) begin
        count_r <= count_r - CNT_W'(1);
      end

      if (cmd.load) begin
        ptr_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= '0;
      end else if (cmd.rewind) begin
        ptr_r  <= PTR_W'(chk_idx_r) + PTR_W'(1);
        pend_r <= 1'b0;
      end else if (cmd.step) begin
        ptr_r     <= ptr_r + PTR_W'(1);
        pend_r    <= 1'b1;
        inr_r     <= ptr_r < PTR_W'(count_r);
        chk_idx_r <= ptr_r[IDX_W-1:0];
      end

      if (cmd.capture) begin
        hit_r <= chk_idx_r;
      end
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.full     = count_r == CNT_W'(CAPACITY);
    sts.pos_ok   = CMP_W'(pos_r) < CMP_W'(count_r);
    sts.match    = pend_r && inr_r && (rdata_r == value_r);
    sts.scan_end = pend_r && !inr_r;
  end

  assign found_index = FOUND_W'(hit_r);
  assign entry_count = ENTRY_COUNT_W'(count_r);

endmodule

`default_nettype wire

>>> sv/sle_ctrl.sv
`default_nettype none

module sle_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  output sle_pkg::dp_cmd_t              cmd,
  input  sle_pkg::dp_sts_t              sts,
  output logic                          out_valid,
  output logic [sle_pkg::STATUS_W-1:0]  out_status
);
  import sle_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t  state_r, state_nxt;
  logic    valid_r, valid_nxt;
  status_t status_r, status_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        valid_nxt  = 1'b1;
        status_nxt = ST_DONE;
        state_nxt  = S_IDLE;
        unique case (sts.op)
          OP_APPEND: begin
            if (sts.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          OP_REMOVE, OP_SEARCH: begin
            valid_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
          OP_ALTER: begin
            if (sts.pos_ok) begin
              cmd.alter = 1'b1;
            end else begin
              status_nxt = ST_BADPOS;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        priority if (sts.match) begin
          if (sts.op == OP_REMOVE) begin
            cmd.rewind = 1'b1;
            state_nxt  = S_SHIFT;
          end else begin
            cmd.capture = 1'b1;
            valid_nxt   = 1'b1;
            status_nxt  = ST_DONE;
            state_nxt   = S_IDLE;
          end
        end else if (sts.scan_end) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SHIFT: begin
        cmd.step  = 1'b1;
        cmd.shift = 1'b1;
        if (sts.scan_end) begin
          cmd.dec    = 1'b1;
          valid_nxt  = 1'b1;
          status_nxt = ST_DONE;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= 1'b0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_valid  = valid_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

>>> bench/sequential_list_engine_tb.sv
module sequential_list_engine_tb;
  import sle_pkg::*;

  localparam int DEPTH         = CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 2 * DEPTH + 8;
  localparam int POOL_SIZE     = 8;
  localparam int QUIET_FIRST   = 600;
  localparam int QUIET_LAST    = 900;
  localparam int MODE_SPAN     = 150;
  localparam int ROW_COUNT     = 25;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [FOUND_W-1:0]       found_index;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic [5:0]         repeats;
    logic               typed;
    list_result_t       want;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          in_operation = OP_CLEAR;
  logic [VALUE_W-1:0]       in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [FOUND_W-1:0]       out_found_index;
  logic [ENTRY_COUNT_W-1:0] out_entry_count;

  logic [VALUE_W-1:0] shadow_entries [DEPTH];
  int unsigned        shadow_count = 0;
  list_result_t       pending_results [$];
  stim_row_t          directed_rows [ROW_COUNT];
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];
  int                 fail_count = 0;
  int                 stall_cycles = 0;
  bit                 idle_enabled = 1'b1;

  sequential_list_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic stim_row_t chk(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                    logic [POS_W-1:0] position, status_t status,
                                    int found, int entries);
    stim_row_t r;
    r.op       = op;
    r.value    = value;
    r.position = position;
    r.repeats  = 6'd1;
    r.typed    = 1'b1;
    r.want     = '{status, FOUND_W'(found), ENTRY_COUNT_W'(entries)};
    return r;
  endfunction

  function automatic stim_row_t run(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                    logic [POS_W-1:0] position, int repeats);
    stim_row_t r;
    r          = '0;
    r.op       = op;
    r.value    = value;
    r.position = position;
    r.repeats  = 6'(repeats);
    return r;
  endfunction

  function automatic list_result_t list_apply(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                              logic [POS_W-1:0] position);
    list_result_t r;
    int           hit;
    r.status      = ST_DONE;
    r.found_index = '0;
    hit           = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_entries[i] == value) hit = i;
    end
    case (op)
      OP_APPEND: begin
        if (shadow_count < DEPTH) begin
          shadow_entries[shadow_count] = value;
          shadow_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) r.found_index = FOUND_W'(hit);
        else r.status = ST_NOTFOUND;
      end
      OP_ALTER: begin
        if (position < shadow_count) shadow_entries[position] = value;
        else r.status = ST_BADPOS;
      end
      OP_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = ENTRY_COUNT_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(9) < 7) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic pause();
    if (idle_enabled && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                      logic [POS_W-1:0] position, bit typed, list_result_t want);
    list_result_t got;
    in_operation <= op;
    in_value     <= value;
    in_position  <= position;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    got = list_apply(op, value, position);
    pending_results.push_back(typed ? want : got);
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: status %0d index %0d count %0d",
               out_status, out_found_index, out_entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, out_found_index);
          fail_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL sequential_list_engine");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    bit                 filling;
    int                 pick;

    // The stale values left behind by a clear must stay invisible to search.
    directed_rows = '{
      chk(OP_SEARCH, 32'h0000_0000, 0, ST_NOTFOUND, 0, 0),
      chk(OP_REMOVE, 32'h0000_0005, 0, ST_NOTFOUND, 0, 0),
      chk(OP_ALTER, 32'h0000_0001, 0, ST_BADPOS, 0, 0),
      chk(OP_APPEND, 32'h8000_0000, 0, ST_DONE, 0, 1),
      chk(OP_APPEND, 32'h7FFF_FFFF, 15, ST_DONE, 0, 2),
      chk(OP_APPEND, 32'hFFFF_FFFF, 0, ST_DONE, 0, 3),
      chk(OP_APPEND, 32'h0000_0000, 0, ST_DONE, 0, 4),
      chk(OP_SEARCH, 32'h7FFF_FFFF, 0, ST_DONE, 1, 4),
      chk(OP_ALTER, 32'h1234_5678, 15, ST_BADPOS, 0, 4),
      chk(OP_ALTER, 32'h1234_5678, 4, ST_BADPOS, 0, 4),
      chk(OP_ALTER, 32'h7FFF_FFFF, 3, ST_DONE, 0, 4),
      chk(OP_REMOVE, 32'h7FFF_FFFF, 0, ST_DONE, 0, 3),
      chk(OP_SEARCH, 32'h7FFF_FFFF, 0, ST_DONE, 2, 3),
      chk(OP_SPARE_FIRST, 32'hFFFF_FFFF, 15, ST_DONE, 0, 3),
      chk(OP_SPARE_LAST, 32'h0000_0000, 0, ST_DONE, 0, 3),
      chk(OP_CLEAR, 32'h0000_0000, 0, ST_DONE, 0, 0),
      chk(OP_SEARCH, 32'h8000_0000, 0, ST_NOTFOUND, 0, 0),
      run(OP_APPEND, 32'h55AA_0000, 0, DEPTH),
      chk(OP_APPEND, 32'h0BAD_F00D, 0, ST_FULL, 0, 16),
      chk(OP_SEARCH, 32'h55AA_000F, 0, ST_DONE, 15, 16),
      chk(OP_ALTER, 32'hFFFF_FFFF, 15, ST_DONE, 0, 16),
      chk(OP_REMOVE, 32'h55AA_0000, 0, ST_DONE, 0, 15),
      chk(OP_SEARCH, 32'hFFFF_FFFF, 0, ST_DONE, 14, 15),
      chk(OP_ALTER, 32'h0000_0000, 15, ST_BADPOS, 0, 15),
      chk(OP_CLEAR, 32'hFFFF_FFFF, 0, ST_DONE, 0, 0)
    };
    value_pool = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, $urandom, $urandom, $urandom};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].repeats; k++) begin
        pause();
        send(directed_rows[r].op, directed_rows[r].value + k, directed_rows[r].position,
             directed_rows[r].typed, directed_rows[r].want);
      end
    end

    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_enabled = !(n >= QUIET_FIRST && n < QUIET_LAST);
      if (n % MODE_SPAN == 0) begin
        filling = 1'($urandom_range(1));
        value_pool[$urandom_range(POOL_SIZE - 1, 5)] = $urandom;
      end
      pick     = $urandom_range(99);
      value    = pick_value();
      position = POS_W'($urandom);
      if (pick < 3) begin
        op = OP_CLEAR;
      end else if (pick < 6) begin
        op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end else if (pick < (filling ? 50 : 22)) begin
        op = OP_APPEND;
      end else if (pick < 82) begin
        op = (pick < (filling ? 65 : 60)) ? OP_REMOVE : OP_SEARCH;
        if (shadow_count > 0 && $urandom_range(1))
          value = shadow_entries[$urandom_range(shadow_count - 1)];
      end else begin
        op = OP_ALTER;
        if (shadow_count > 0 && $urandom_range(3) != 0)
          position = POS_W'($urandom_range(shadow_count - 1));
      end
      pause();
      send(op, value, position, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sequential_list_engine");
    end else begin
      $display("FAIL sequential_list_engine");
    end
    $finish;
  end

endmodule
